// File: rtl/tlv_command_deframer_assert.svh
// Assertion macros for the deframer, clocked on clock, off during reset.
`ifndef TLV_COMMAND_DEFRAMER_ASSERT_SVH
`define TLV_COMMAND_DEFRAMER_ASSERT_SVH

// Condition must never hold.
`define TLVCD_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TLVCD_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: rtl/tlvcd_pkg.sv
package tlvcd_pkg;

   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_REBOOT = 3'd1,
      ACT_MODE   = 3'd2,
      ACT_BRIGHT = 3'd3,
      ACT_VOLUME = 3'd4
   } action_kind_type;

   typedef enum logic [1:0] {
      FAULT_OK          = 2'd0,
      FAULT_BAD_MODE    = 2'd1,
      FAULT_UNSUPPORTED = 2'd2
   } fault_type;

   typedef enum logic [1:0] {
      TAIL_CLEAN     = 2'd0,
      TAIL_HEADER    = 2'd1,
      TAIL_TRUNCATED = 2'd2
   } tail_type;

   localparam logic [15:0] ID_REBOOT = 16'd101;
   localparam logic [15:0] ID_MODE   = 16'd102;
   localparam logic [15:0] ID_BRIGHT = 16'd103;
   localparam logic [15:0] ID_VOLUME = 16'd104;

   localparam logic [2:0] HDR_ID_LO  = 3'd0;
   localparam logic [2:0] HDR_ID_HI  = 3'd1;
   localparam logic [2:0] HDR_LEN_LO = 3'd3;
   localparam logic [2:0] HDR_LEN_HI = 3'd4;

   localparam logic [15:0] WORD_BYTES = 16'd4;
   localparam logic [31:0] MODE_MAX   = 32'd4;

   localparam int          CSR_ADDR_W = 4;
   localparam logic [1:0]  REG_BRIGHT_FLOOR   = 2'd0;
   localparam logic [1:0]  REG_BRIGHT_CEILING = 2'd1;
   localparam logic [1:0]  REG_VOLUME_FLOOR   = 2'd2;
   localparam logic [1:0]  REG_VOLUME_CEILING = 2'd3;

   typedef struct packed {
      logic            frame_done;
      logic [15:0]     frame_ident;
      action_kind_type action_kind;
      logic [7:0]      action_value;
      fault_type       frame_fault;
      logic            payload_over;
      logic            payload_ok;
      tail_type        tail_state;
   } result_type;

   function automatic logic [7:0] clamp_level(logic [31:0] word, logic [7:0] lo,
                                              logic [7:0] hi);
      logic [31:0] r;
      if (word[31] || (word < {24'h000000, lo})) r = {24'h000000, lo};
      else r = word;
      if (r > {24'h000000, hi}) r = {24'h000000, hi};
      return r[7:0];
   endfunction

endpackage

// File: rtl/tlv_command_deframer.sv
// TLV command deframer.
// Input channel req_: one payload byte per transfer, req_end_of_payload on the
// final byte. Frames are id (16b LE), type byte, length (16b LE), value.
// Result channel rsp_: one result on a byte that completes a frame or ends the
// payload, no result otherwise.
// Each result is registered in the result queue before it appears on rsp_.
// Throughput: one byte per cycle while req_ready is high; the per-byte parser
// update is a single pass from the state registers to the result register.
// A two-entry result queue (output register plus skid) sits at rsp_; while
// the receiver stalls, bytes keep being taken until the skid entry fills,
// then req_ready drops until a result leaves.
// Configuration: APB-style csr_ port, four 8-bit limit registers at byte
// addresses 0, 4, 8, 12; write only while idle.
// Reset (synchronous, active high) clears the parser and the queue and loads
// the default limits; a payload end also clears the parser state.
`include "tlv_command_deframer_assert.svh"

module tlv_command_deframer import tlvcd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_end_of_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_frame_done,
   output logic [15:0]           rsp_frame_ident,
   output logic [2:0]            rsp_action_kind,
   output logic [7:0]            rsp_action_value,
   output logic [1:0]            rsp_frame_fault,
   output logic                  rsp_payload_over,
   output logic                  rsp_payload_ok,
   output logic [1:0]            rsp_tail_state,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [7:0]  bright_floor_ff, bright_ceiling_ff, volume_floor_ff, volume_ceiling_ff;
   logic        phase_ff, phase_in;
   logic [2:0]  hcnt_ff, hcnt_in;
   logic [15:0] ident_ff, ident_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] vcnt_ff, vcnt_in;
   logic [31:0] word_ff, word_in;
   logic        seen_ff, seen_in;
   logic        reboot_ff, reboot_in;
   logic        complete, has_result, four;
   result_type  res;
   result_type  head_ff, head_in, skid_ff, skid_in;
   logic        head_v_ff, head_v_in, skid_v_ff, skid_v_in;
   logic        accept, push, pop, csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[3:2])
         REG_BRIGHT_FLOOR:   csr_prdata = {24'h000000, bright_floor_ff};
         REG_BRIGHT_CEILING: csr_prdata = {24'h000000, bright_ceiling_ff};
         REG_VOLUME_FLOOR:   csr_prdata = {24'h000000, volume_floor_ff};
         REG_VOLUME_CEILING: csr_prdata = {24'h000000, volume_ceiling_ff};
         default:            csr_prdata = 32'h00000000;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_floor_ff   <= 8'd0;
         bright_ceiling_ff <= 8'd255;
         volume_floor_ff   <= 8'd0;
         volume_ceiling_ff <= 8'd100;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_BRIGHT_FLOOR:   bright_floor_ff   <= csr_pwdata[7:0];
            REG_BRIGHT_CEILING: bright_ceiling_ff <= csr_pwdata[7:0];
            REG_VOLUME_FLOOR:   volume_floor_ff   <= csr_pwdata[7:0];
            REG_VOLUME_CEILING: volume_ceiling_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      hcnt_in   = hcnt_ff;
      ident_in  = ident_ff;
      len_in    = len_ff;
      vcnt_in   = vcnt_ff;
      word_in   = word_ff;
      seen_in   = seen_ff;
      reboot_in = reboot_ff;
      complete  = 1'b0;
      res       = '0;
      if (!reboot_ff) begin
         if (!phase_ff) begin
            case (hcnt_ff)
               HDR_ID_LO:  ident_in = {8'h00, req_data_byte};
               HDR_ID_HI:  ident_in = {req_data_byte, ident_ff[7:0]};
               HDR_LEN_LO: len_in   = {8'h00, req_data_byte};
               HDR_LEN_HI: len_in   = {req_data_byte, len_ff[7:0]};
               default: ;
            endcase
            if (hcnt_ff == HDR_LEN_HI) begin
               hcnt_in = HDR_ID_LO;
               vcnt_in = 16'd0;
               word_in = 32'd0;
               if (len_in == 16'd0) complete = 1'b1;
               else phase_in = 1'b1;
            end else begin
               hcnt_in = hcnt_ff + 3'd1;
            end
         end else begin
            if (vcnt_ff < WORD_BYTES) begin
               word_in = word_ff | ({24'h000000, req_data_byte} << {vcnt_ff[1:0], 3'b000});
            end
            vcnt_in = vcnt_ff + 16'd1;
            if (vcnt_in == len_ff) begin
               phase_in = 1'b0;
               complete = 1'b1;
            end
         end
      end
      four = len_in >= WORD_BYTES;
      if (complete) begin
         res.frame_done  = 1'b1;
         res.frame_ident = ident_in;
         seen_in         = 1'b1;
         case (ident_in)
            ID_REBOOT: begin
               if ((len_in != 16'd0) && (word_in[7:0] != 8'h00)) begin
                  res.action_kind = ACT_REBOOT;
                  reboot_in       = 1'b1;
               end
            end
            ID_MODE: begin
               if (four) begin
                  if (word_in <= MODE_MAX) begin
                     res.action_kind  = ACT_MODE;
                     res.action_value = word_in[7:0];
                  end else begin
                     res.frame_fault = FAULT_BAD_MODE;
                  end
               end
            end
            ID_BRIGHT: begin
               if (four) begin
                  res.action_kind  = ACT_BRIGHT;
                  res.action_value = clamp_level(word_in, bright_floor_ff, bright_ceiling_ff);
               end
            end
            ID_VOLUME: begin
               if (four) begin
                  res.action_kind  = ACT_VOLUME;
                  res.action_value = clamp_level(word_in, volume_floor_ff, volume_ceiling_ff);
               end
            end
            default: res.frame_fault = FAULT_UNSUPPORTED;
         endcase
      end
      has_result = complete || req_end_of_payload;
      if (req_end_of_payload) begin
         res.payload_over = 1'b1;
         res.payload_ok   = seen_in;
         if (reboot_in) res.tail_state = TAIL_CLEAN;
         else if (phase_in) res.tail_state = TAIL_TRUNCATED;
         else if (hcnt_in != HDR_ID_LO) res.tail_state = TAIL_HEADER;
         else res.tail_state = TAIL_CLEAN;
         phase_in  = 1'b0;
         hcnt_in   = 3'd0;
         ident_in  = 16'd0;
         len_in    = 16'd0;
         vcnt_in   = 16'd0;
         word_in   = 32'd0;
         seen_in   = 1'b0;
         reboot_in = 1'b0;
      end
   end

   assign req_ready = !skid_v_ff;
   assign accept    = req_valid && req_ready;
   assign push      = accept && has_result;
   assign pop       = head_v_ff && rsp_ready;

   always_comb begin
      head_in   = head_ff;
      skid_in   = skid_ff;
      head_v_in = head_v_ff;
      skid_v_in = skid_v_ff;
      if (pop) begin
         if (skid_v_ff) begin
            head_in   = skid_ff;
            skid_v_in = 1'b0;
         end else begin
            head_v_in = 1'b0;
         end
      end
      if (push) begin
         if (!head_v_in) begin
            head_in   = res;
            head_v_in = 1'b1;
         end else begin
            skid_in   = res;
            skid_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 1'b0;
         hcnt_ff   <= 3'd0;
         ident_ff  <= 16'd0;
         len_ff    <= 16'd0;
         vcnt_ff   <= 16'd0;
         word_ff   <= 32'd0;
         seen_ff   <= 1'b0;
         reboot_ff <= 1'b0;
         head_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            hcnt_ff   <= hcnt_in;
            ident_ff  <= ident_in;
            len_ff    <= len_in;
            vcnt_ff   <= vcnt_in;
            word_ff   <= word_in;
            seen_ff   <= seen_in;
            reboot_ff <= reboot_in;
         end
         head_v_ff <= head_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = head_v_ff;
   assign rsp_frame_done   = head_ff.frame_done;
   assign rsp_frame_ident  = head_ff.frame_ident;
   assign rsp_action_kind  = head_ff.action_kind;
   assign rsp_action_value = head_ff.action_value;
   assign rsp_frame_fault  = head_ff.frame_fault;
   assign rsp_payload_over = head_ff.payload_over;
   assign rsp_payload_ok   = head_ff.payload_ok;
   assign rsp_tail_state   = head_ff.tail_state;

   `TLVCD_ASSERT_NEVER(a_skid_without_head, skid_v_ff && !head_v_ff, "skid entry without head entry")
   `TLVCD_ASSERT_IMPLIES(a_action_needs_frame, rsp_valid && (rsp_action_kind != ACT_NONE), rsp_frame_done, "action on a result without a finished frame")
   `TLVCD_ASSERT_IMPLIES(a_end_fields_only_at_end, rsp_valid && !rsp_payload_over, !rsp_payload_ok && (rsp_tail_state == TAIL_CLEAN), "payload end fields set before payload end")
   `TLVCD_ASSERT_IMPLIES(a_reboot_at_boundary, reboot_ff, !phase_ff && (hcnt_ff == HDR_ID_LO), "reboot latched inside a frame")

endmodule
